// ===== sv/trd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tiled RGBA8 texture detiler: geometry constants,
// request payload types and the sequencer state type. No dependencies.
package trd_pkg;

    localparam int IMAGE_SIDE    = 64;
    localparam int HEADER_BYTES  = 16;

    localparam int TILE_BYTES    = 64;
    localparam int TILE_PIXELS   = 16;
    localparam int TILES_PER_ROW = IMAGE_SIDE / 4;
    localparam int TILE_COUNT    = TILES_PER_ROW * TILES_PER_ROW;

    localparam int POS_W = $clog2(HEADER_BYTES + TILE_COUNT * TILE_BYTES + 1);
    localparam int TXY_W = (TILES_PER_ROW > 1) ? $clog2(TILES_PER_ROW) : 1;
    localparam int PIX_W = $clog2(TILE_PIXELS);

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_flag;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] pixel_rgba;
        logic [11:0] pixel_index;
        logic        tile_last;
        logic        image_last;
    } pixel_req_t;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_DRAIN  = 2'b10
    } state_t;

endpackage

// ===== sv/trd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
module trd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tiled_rgba8_texture_detiler.sv =====
`timescale 1ns / 1ps
// Top level of the tiled RGBA8 texture detiler.
// Depends on trd_pkg and trd_ram (16 x 32 tile pixel store).
//
// Usage:
//   byte channel  : byte_valid / byte_stall / byte_data, one file byte per
//                   request; start_flag marks the first header byte.
//   pixel channel : pixel_valid / pixel_stall / pixel_data, one RGBA pixel
//                   per request with its linear index and tile/image marks.
//   Bytes are taken one per cycle while a tile is being filled. The last
//   byte of a tile starts a drain of the 16 pixels from the tile store, one
//   store read per cycle while the pixel channel does not stall; byte_stall
//   stays high until the last pixel has left the store read register. After
//   the last tile byte is taken, the state register enters the drain, then
//   the store read register and the output register take the first pixel.
//   Alpha/red pairs are written to the store directly; green/blue pairs
//   read back the stored half and write the merged word.
//   Reset clears position, tile counters, image-done flag and all valids;
//   the store needs no clearing. A stall on the pixel channel holds the
//   output register and backs up the drain, which then holds byte_stall.
//   Bytes after the final tile are taken and dropped until the next start.
module tiled_rgba8_texture_detiler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  trd_pkg::byte_req_t  byte_data,
    output logic               pixel_valid,
    input  logic               pixel_stall,
    output trd_pkg::pixel_req_t pixel_data
);

    localparam logic [trd_pkg::POS_W-1:0] HDR = trd_pkg::POS_W'(trd_pkg::HEADER_BYTES);
    localparam logic [trd_pkg::TXY_W-1:0] TXY_LAST =
        trd_pkg::TXY_W'(trd_pkg::TILES_PER_ROW - 1);
    localparam logic [trd_pkg::PIX_W-1:0] PIX_LAST =
        trd_pkg::PIX_W'(trd_pkg::TILE_PIXELS - 1);

    trd_pkg::state_t state_reg, state_next;
    logic [trd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      done_reg, done_next;
    logic [trd_pkg::TXY_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [trd_pkg::TXY_W-1:0] drain_tx_reg, drain_tx_next, drain_ty_reg, drain_ty_next;
    logic [trd_pkg::PIX_W-1:0] drain_k_reg, drain_k_next, rd_k_reg, rd_k_next;
    logic                      issuing_reg, issuing_next;
    logic                      rdv_reg, rdv_next;
    logic [7:0]                pair_reg, pair_next;
    logic                      out_valid_reg, out_valid_next;
    trd_pkg::pixel_req_t       out_reg, out_next;

    logic                      accept, load;
    logic [trd_pkg::POS_W-1:0] pos_eff, d;
    logic                      done_eff;
    logic [trd_pkg::TXY_W-1:0] tx_eff, ty_eff;
    logic [5:0]                off;
    logic                      we, re;
    logic [trd_pkg::PIX_W-1:0] waddr, raddr;
    logic [31:0]               wdata, rdata;
    logic [31:0]               row_w, col_w, idx_w;

    trd_ram #(
        .WIDTH(32),
        .DEPTH(trd_pkg::TILE_PIXELS)
    ) u_tile_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign accept      = byte_valid && !byte_stall;
    assign byte_stall  = (state_reg != trd_pkg::ST_ACCEPT);
    assign load        = rdv_reg && (!out_valid_reg || !pixel_stall);
    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_reg;

    assign pos_eff  = byte_data.start_flag ? '0 : pos_reg;
    assign done_eff = byte_data.start_flag ? 1'b0 : done_reg;
    assign tx_eff   = byte_data.start_flag ? '0 : tx_reg;
    assign ty_eff   = byte_data.start_flag ? '0 : ty_reg;
    assign d        = pos_eff - HDR;
    assign off      = d[5:0];

    assign row_w = (32'(drain_ty_reg) * 32'd4) + 32'(rd_k_reg[3:2]);
    assign col_w = (32'(drain_tx_reg) * 32'd4) + 32'(rd_k_reg[1:0]);
    assign idx_w = row_w * 32'(trd_pkg::IMAGE_SIDE) + col_w;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        drain_tx_next  = drain_tx_reg;
        drain_ty_next  = drain_ty_reg;
        drain_k_next   = drain_k_reg;
        rd_k_next      = rd_k_reg;
        issuing_next   = issuing_reg;
        rdv_next       = rdv_reg;
        pair_next      = pair_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = off[4:1];
        wdata          = {byte_data.byte_value, 16'h0000, pair_reg};
        re             = 1'b0;
        raddr          = off[4:1];

        unique case (state_reg)
            trd_pkg::ST_ACCEPT:
            begin
                if (accept)
                begin
                    pos_next  = pos_eff;
                    done_next = done_eff;
                    tx_next   = tx_eff;
                    ty_next   = ty_eff;
                    if (!done_eff)
                    begin
                        pos_next = pos_eff + 1'b1;
                        if (pos_eff >= HDR)
                        begin
                            if (!off[0])
                            begin
                                pair_next = byte_data.byte_value;
                                re        = off[5];
                            end
                            else
                            begin
                                we = 1'b1;
                                if (off[5])
                                begin
                                    wdata = {rdata[31:24], pair_reg,
                                             byte_data.byte_value, rdata[7:0]};
                                end
                            end
                            if (off == 6'(trd_pkg::TILE_BYTES - 1))
                            begin
                                state_next    = trd_pkg::ST_DRAIN;
                                drain_k_next  = '0;
                                issuing_next  = 1'b1;
                                drain_tx_next = tx_eff;
                                drain_ty_next = ty_eff;
                                if (tx_eff == TXY_LAST)
                                begin
                                    tx_next = '0;
                                    if (ty_eff == TXY_LAST)
                                    begin
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        ty_next = ty_eff + 1'b1;
                                    end
                                end
                                else
                                begin
                                    tx_next = tx_eff + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            trd_pkg::ST_DRAIN:
            begin
                raddr = drain_k_reg;
                if (issuing_reg && (!rdv_reg || load))
                begin
                    re        = 1'b1;
                    rd_k_next = drain_k_reg;
                    if (drain_k_reg == PIX_LAST)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        drain_k_next = drain_k_reg + 1'b1;
                    end
                end
                if (!issuing_reg && !rdv_reg)
                begin
                    state_next = trd_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = trd_pkg::ST_ACCEPT;
            end
        endcase

        // hold the read data until the output register takes it
        if (re && (state_reg == trd_pkg::ST_DRAIN))
        begin
            rdv_next = 1'b1;
        end
        else if (load)
        begin
            rdv_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next         = 1'b1;
            out_next.pixel_rgba    = rdata;
            out_next.pixel_index   = idx_w[11:0];
            out_next.tile_last     = (rd_k_reg == PIX_LAST);
            out_next.image_last    = (rd_k_reg == PIX_LAST) && (drain_tx_reg == TXY_LAST)
                                     && (drain_ty_reg == TXY_LAST);
        end
        else if (!pixel_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trd_pkg::ST_ACCEPT;
            pos_reg       <= '0;
            done_reg      <= 1'b0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            drain_k_reg   <= '0;
            issuing_reg   <= 1'b0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            drain_k_reg   <= drain_k_next;
            issuing_reg   <= issuing_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_tx_reg <= drain_tx_next;
        drain_ty_reg <= drain_ty_next;
        rd_k_reg     <= rd_k_next;
        pair_reg     <= pair_next;
        out_reg      <= out_next;
    end

endmodule
